>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rating statistics block
// no dependencies; include by bare file name where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RMM_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

`define RMM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`else

`define RMM_ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define RMM_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

>>> hw/rtl/rmm_pkg.sv
// constants, widths and shared types of the rating statistics block
// no dependencies; compiled first
package rmm_pkg;

   localparam int MAX_ITEMS   = 128;
   localparam int MAX_RATING  = 9;
   localparam int NUM_BINS    = MAX_RATING + 1;

   localparam int RATING_W    = 4;
   localparam int TOTAL_W     = 11;
   localparam int COUNT_W     = 8;
   localparam int BIN_IDX_W   = $clog2(NUM_BINS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [RATING_W-1:0] rating;
      logic                in_range;
      logic                last_item;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic scanning;
      logic emitting;
   } back_status_type;

   typedef enum logic [1:0] {
      BACK_ACCUM,
      BACK_SCAN,
      BACK_EMIT
   } back_state_type;

endpackage

>>> hw/rtl/rmm_if.sv
// request and response channel interfaces of the rating statistics block
// depends on rmm_pkg
interface rmm_req_if import rmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RATING_W-1:0] rating;
   logic                last_item;

   modport source (output valid, output rating, output last_item, input ready);
   modport sink   (input valid, input rating, input last_item, output ready);
endinterface

interface rmm_rsp_if import rmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TOTAL_W-1:0]  sum_total;
   logic [COUNT_W-1:0]  item_count;
   logic [RATING_W-1:0] median_value;
   logic [RATING_W-1:0] mode_value;
   logic [COUNT_W-1:0]  mode_frequency;
   logic                range_error;

   modport source (output valid, output sum_total, output item_count,
                   output median_value, output mode_value, output mode_frequency,
                   output range_error, input ready);
   modport sink   (input valid, input sum_total, input item_count,
                   input median_value, input mode_value, input mode_frequency,
                   input range_error, output ready);
endinterface

>>> hw/rtl/rmm_front.sv
// front end: takes requests, checks the rating range and pushes them to the queue
// depends on rmm_pkg and rmm_if
module rmm_front import rmm_pkg::*; (
   rmm_req_if.sink         req,
   input  queue_status_type q_status,
   output logic             push,
   output queue_entry_type  push_entry
);

   assign req.ready = !q_status.full;
   assign push      = req.valid && !q_status.full;

   always_comb begin
      push_entry.rating    = req.rating;
      push_entry.in_range  = ({{(32-RATING_W){1'b0}}, req.rating} <= 32'(MAX_RATING));
      push_entry.last_item = req.last_item;
   end

endmodule

>>> hw/rtl/rmm_queue.sv
// short queue between front and back ends
// depends on rmm_pkg
module rmm_queue import rmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  push_entry,
   input  logic             pop,
   output queue_entry_type  pop_entry,
   output queue_status_type status
);

   queue_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      pop_entry    = entry_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/rmm_back.sv
// back end: histogram bins, running sums, bin scan and the response register
// depends on rmm_pkg and rmm_if
module rmm_back import rmm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  queue_entry_type q_entry,
   output logic            q_pop,
   output back_status_type status,
   rmm_rsp_if.source       rsp
);

   back_state_type        state_ff, state_in;

   logic [COUNT_W-1:0]    hist_ff [NUM_BINS];
   logic [TOTAL_W-1:0]    total_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic                  error_ff;

   logic [BIN_IDX_W-1:0]  idx_ff;
   logic [COUNT_W-1:0]    cum_ff;
   logic                  found_ff;
   logic [RATING_W-1:0]   median_ff;
   logic [RATING_W-1:0]   mode_ff;
   logic [COUNT_W-1:0]    best_ff;

   logic                  rsp_valid_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [RATING_W-1:0]   rsp_median_ff;
   logic [RATING_W-1:0]   rsp_mode_ff;
   logic [COUNT_W-1:0]    rsp_freq_ff;
   logic                  rsp_error_ff;

   logic                  scan_en;
   logic                  emit_load;
   logic                  upd;
   logic                  scan_done;
   logic                  out_free;
   logic [COUNT_W-1:0]    bin_val;
   logic [COUNT_W-1:0]    cum_next;
   logic [COUNT_W-1:0]    target;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign scan_done = (idx_ff == BIN_IDX_W'(NUM_BINS - 1));
   assign bin_val   = hist_ff[idx_ff];
   assign cum_next  = cum_ff + bin_val;
   assign target    = count_ff >> 1;
   assign upd       = q_pop && q_entry.in_range && (count_ff < COUNT_W'(MAX_ITEMS));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_ACCUM: begin
            if (q_valid && q_entry.last_item) begin
               state_in = BACK_SCAN;
            end
         end
         BACK_SCAN: begin
            if (scan_done) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               state_in = BACK_ACCUM;
            end
         end
         default: state_in = BACK_ACCUM;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = 1'b0;
      scan_en   = 1'b0;
      emit_load = 1'b0;
      unique case (state_ff)
         BACK_ACCUM: q_pop     = q_valid;
         BACK_SCAN:  scan_en   = 1'b1;
         BACK_EMIT:  emit_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      status.scanning = scan_en;
      status.emitting = (state_ff == BACK_EMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   // histogram and running sums
   always_ff @(posedge clock) begin
      if (reset || emit_load) begin
         for (int b = 0; b < NUM_BINS; b++) begin
            hist_ff[b] <= '0;
         end
         total_ff <= '0;
         count_ff <= '0;
         error_ff <= 1'b0;
      end else begin
         for (int b = 0; b < NUM_BINS; b++) begin
            if (upd && (q_entry.rating == RATING_W'(b))) begin
               hist_ff[b] <= hist_ff[b] + 1'b1;
            end
         end
         if (upd) begin
            total_ff <= total_ff + TOTAL_W'(q_entry.rating);
            count_ff <= count_ff + 1'b1;
         end
         if (q_pop && !q_entry.in_range) begin
            error_ff <= 1'b1;
         end
      end
   end

   // bin scan for median and mode
   always_ff @(posedge clock) begin
      if (q_pop) begin
         idx_ff    <= '0;
         cum_ff    <= '0;
         found_ff  <= 1'b0;
         median_ff <= '0;
         mode_ff   <= '0;
         best_ff   <= '0;
      end else if (scan_en) begin
         idx_ff <= idx_ff + 1'b1;
         cum_ff <= cum_next;
         if (!found_ff && (cum_next > target)) begin
            found_ff  <= 1'b1;
            median_ff <= RATING_W'(idx_ff);
         end
         if ((idx_ff != '0) && (bin_val > best_ff)) begin
            best_ff <= bin_val;
            mode_ff <= RATING_W'(idx_ff);
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_total_ff  <= total_ff;
         rsp_count_ff  <= count_ff;
         rsp_median_ff <= median_ff;
         rsp_mode_ff   <= mode_ff;
         rsp_freq_ff   <= best_ff;
         rsp_error_ff  <= error_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.sum_total      = rsp_total_ff;
   assign rsp.item_count     = rsp_count_ff;
   assign rsp.median_value   = rsp_median_ff;
   assign rsp.mode_value     = rsp_mode_ff;
   assign rsp.mode_frequency = rsp_freq_ff;
   assign rsp.range_error    = rsp_error_ff;

endmodule

>>> hw/rtl/rating_mean_median_mode.sv
// Rating statistics: collects a set of ratings (0 to 9, last one marked) and returns one
// response per set with total, count, median, mode and mode frequency. The front end
// takes one request per cycle, while the queue is not full, into a four-entry queue; the
// back end drains the queue at one request per cycle while accumulating, each counted
// request bumping one histogram bin. After the marked request the back end scans the ten
// bins, one bin per cycle, then loads the response register once it is free; during the
// scan the queue still takes up to four requests of the next set.
// Ratings above 9 are not counted and set range_error; counts saturate at 128 items.
// depends on rmm_pkg, rmm_if, rmm_front, rmm_queue, rmm_back and assert_macros.svh
`include "assert_macros.svh"

module rating_mean_median_mode import rmm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rmm_req_if.sink   req_channel,
   rmm_rsp_if.source rsp_channel
);

   queue_status_type q_status;
   queue_entry_type  push_entry;
   queue_entry_type  pop_entry;
   back_status_type  back_status;
   logic             push;
   logic             pop;

   rmm_front u_front (
      .req        (req_channel),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   rmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   rmm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (!q_status.empty),
      .q_entry (pop_entry),
      .q_pop   (pop),
      .status  (back_status),
      .rsp     (rsp_channel)
   );

   `RMM_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, q_status.full, !push)
   `RMM_ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, !q_status.empty)
   `RMM_ASSERT_IMPLIES(a_no_pop_while_busy, clock, reset,
      back_status.scanning || back_status.emitting, !pop)
   `RMM_ASSERT_NEXT(a_emit_sets_valid, clock, reset,
      back_status.emitting && !back_status.scanning, rsp_channel.valid || $past(rsp_channel.ready))

endmodule

>>> sim/rmm_stats_checker.sv
// checker for the rating statistics block: watches both channels, keeps its own
// histogram, total and count, predicts each set summary and compares it field by field
// depends on rmm_pkg and the rmm_req_if and rmm_rsp_if interfaces
module rmm_stats_checker import rmm_pkg::*; (
   input  logic clock,
   input  logic reset,
   rmm_req_if   req_channel,
   rmm_rsp_if   rsp_channel,
   output int   failures,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [TOTAL_W-1:0]  sum_total;
      logic [COUNT_W-1:0]  item_count;
      logic [RATING_W-1:0] median_value;
      logic [RATING_W-1:0] mode_value;
      logic [COUNT_W-1:0]  mode_frequency;
      logic                range_error;
   } set_summary_type;

   set_summary_type     expected_summaries [$];
   logic [COUNT_W-1:0]  bin_count [NUM_BINS];
   logic [TOTAL_W-1:0]  total_so_far;
   logic [COUNT_W-1:0]  count_so_far;
   logic                rejected_seen;
   int                  mismatch_count = 0;

   function automatic void clear_set();
      foreach (bin_count[v]) bin_count[v] = '0;
      total_so_far  = '0;
      count_so_far  = '0;
      rejected_seen = 1'b0;
   endfunction

   function automatic void absorb_rating(input logic [RATING_W-1:0] rating,
                                         input logic closes_set);
      set_summary_type summary;
      int              cum;
      logic            found;
      if (rating > MAX_RATING) begin
         rejected_seen = 1'b1;
      end else if (count_so_far < MAX_ITEMS) begin
         bin_count[rating] += 1'b1;
         total_so_far      += rating;
         count_so_far      += 1'b1;
      end
      if (closes_set) begin
         summary.sum_total      = total_so_far;
         summary.item_count     = count_so_far;
         summary.median_value   = '0;
         summary.mode_value     = '0;
         summary.mode_frequency = '0;
         summary.range_error    = rejected_seen;
         cum   = 0;
         found = 1'b0;
         // median from cumulative bin counts
         for (int v = 0; v < NUM_BINS; v++) begin
            cum += bin_count[v];
            if (!found && cum > count_so_far / 2) begin
               summary.median_value = RATING_W'(v);
               found = 1'b1;
            end
         end
         // zero never wins the mode
         for (int v = 1; v <= MAX_RATING; v++) begin
            if (bin_count[v] > summary.mode_frequency) begin
               summary.mode_frequency = bin_count[v];
               summary.mode_value     = RATING_W'(v);
            end
         end
         expected_summaries.push_back(summary);
         clear_set();
      end
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      set_summary_type want;
      if (reset) begin
         clear_set();
         expected_summaries.delete();
      end else begin
         if (rsp_channel.valid && rsp_channel.ready) begin
            if (expected_summaries.size() == 0) begin
               $error("response with no request set closed");
               mismatch_count++;
            end else begin
               want = expected_summaries.pop_front();
               check_field("sum_total", want.sum_total, rsp_channel.sum_total);
               check_field("item_count", want.item_count, rsp_channel.item_count);
               check_field("median_value", want.median_value, rsp_channel.median_value);
               check_field("mode_value", want.mode_value, rsp_channel.mode_value);
               check_field("mode_frequency", want.mode_frequency,
                           rsp_channel.mode_frequency);
               check_field("range_error", want.range_error, rsp_channel.range_error);
            end
         end
         if (req_channel.valid && req_channel.ready)
            absorb_rating(req_channel.rating, req_channel.last_item);
      end
      failures <= mismatch_count;
      pending  <= expected_summaries.size();
   end

endmodule

>>> sim/testbench.sv
// top of the rating statistics testbench: clock, reset, request stimulus, response
// back-pressure and the verdict; prediction and comparison sit in rmm_stats_checker
// depends on rmm_pkg, rmm_if, rmm_stats_checker and rating_mean_median_mode
module testbench import rmm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum {
      PH_DIRECTED,
      PH_SLOW_RSP,
      PH_SLOW_REQ,
      PH_PRESSURE,
      PH_FULL_RATE
   } phase_type;

   logic      clock;
   logic      reset;
   phase_type phase;
   int        send_idle_pct;
   int        recv_idle_pct;
   int        items_sent;
   int        failures;
   int        pending;

   rmm_req_if req_ch ();
   rmm_rsp_if rsp_ch ();

   rating_mean_median_mode uut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   rmm_stats_checker stats_check (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch),
      .failures    (failures),
      .pending     (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_rating(input logic [RATING_W-1:0] rating, input logic closes_set);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.rating    <= rating;
      req_ch.last_item <= closes_set;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
   endtask

   task automatic random_set();
      int                  len;
      int                  top_rating;
      int                  error_pct;
      logic                all_nines;
      logic [RATING_W-1:0] rating;
      // now and then a long set, which may saturate the count
      if ($urandom_range(39) == 0)
         len = $urandom_range(140, 120);
      else
         len = $urandom_range(20, 1);
      top_rating = $urandom_range(MAX_RATING);
      error_pct  = ($urandom_range(3) == 0) ? 15 : 0;
      all_nines  = (len > 100) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < error_pct)
            rating = RATING_W'($urandom_range(15, MAX_RATING + 1));
         else if (all_nines)
            rating = RATING_W'(MAX_RATING);
         else
            rating = RATING_W'($urandom_range(top_rating));
         send_rating(rating, i == len - 1);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.rating    = '0;
      req_ch.last_item = 1'b0;
      phase            = PH_DIRECTED;
      send_idle_pct    = 0;
      recv_idle_pct    = 20;
      items_sent       = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // lone zero, then a set holding only a rejected rating
      send_rating(4'd0, 1'b1);
      send_rating(4'd15, 1'b1);
      send_rating(4'd9, 1'b0);
      send_rating(4'd9, 1'b0);
      send_rating(4'd1, 1'b1);
      send_rating(4'd12, 1'b0);
      send_rating(4'd5, 1'b0);
      send_rating(4'd5, 1'b0);
      send_rating(4'd3, 1'b1);
      // tie goes to the lower rating
      send_rating(4'd2, 1'b0);
      send_rating(4'd7, 1'b0);
      send_rating(4'd7, 1'b0);
      send_rating(4'd2, 1'b1);
      // zeros dominate but cannot be the mode
      send_rating(4'd0, 1'b0);
      send_rating(4'd0, 1'b0);
      send_rating(4'd0, 1'b0);
      send_rating(4'd4, 1'b1);
      // rejected rating closing the set
      send_rating(4'd6, 1'b0);
      send_rating(4'd10, 1'b1);
      send_rating(4'd8, 1'b0);
      send_rating(4'd1, 1'b0);
      send_rating(4'd11, 1'b1);

      phase         <= PH_SLOW_RSP;
      send_idle_pct  = 35;
      recv_idle_pct <= 59;
      while (items_sent < 520) random_set();

      phase         <= PH_SLOW_REQ;
      send_idle_pct  = 59;
      recv_idle_pct <= 35;
      while (items_sent < 1000) random_set();

      // short sets against a stalled receiver
      phase         <= PH_PRESSURE;
      send_idle_pct  = 0;
      recv_idle_pct <= 0;
      repeat (12) begin
         send_rating(RATING_W'($urandom_range(MAX_RATING)), 1'b0);
         send_rating(RATING_W'($urandom_range(MAX_RATING)), 1'b0);
         send_rating(RATING_W'($urandom_range(MAX_RATING)), 1'b1);
      end

      phase <= PH_FULL_RATE;
      while (items_sent < 1420) random_set();

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      int   hold_left;
      logic hold_done;
      hold_left    = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (phase == PH_PRESSURE && !hold_done) begin
            hold_left     = 400;
            hold_done     = 1'b1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
